FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define TLT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tlt assertion failed");

// condition in one cycle implies a result in the next
`define TLT_ASSERT_NEXT(label, cond, res) \
	`TLT_ASSERT(label, (cond) |=> (res))

`endif

FILE: hdl/tlt_pkg.sv
`timescale 1ns / 1ps
package tlt_pkg;

	localparam int AVG_DEPTH = 5;

	localparam int IN_W      = 16;
	localparam int IN_DATA_W = 48;
	localparam int DEG_W     = 9;
	localparam int OUT_W     = 24;

	localparam int ANG_W     = 17;
	localparam int ANG_LIMIT = 46080;
	localparam int FRAC_BITS = 8;

	localparam int SCALE_SH  = 14;
	localparam int XY_W      = 34;
	localparam int ACC_W     = 26;
	localparam int RND_W     = ACC_W - FRAC_BITS;
	localparam int STEPS     = 16;
	localparam int STEP_W    = 4;
	localparam int HALF_TURN = 180 * 65536;

	localparam int POS_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W    = ANG_W + POS_W + 1;
	localparam int MAG_W    = SUM_W - 1;
	localparam int Q_W      = MAG_W - FRAC_BITS;
	localparam int RECIP_SH = 24;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / AVG_DEPTH + 1);
	localparam int PROD_W   = Q_W + RECIP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MERGE,
		ST_EMIT
	} tlt_state_t;

	typedef struct packed {
		logic                    done;
		logic signed [ANG_W-1:0] angle;
	} tlt_lane_res_t;

	typedef struct packed {
		logic                    push;
		logic                    load_new;
		logic signed [ANG_W-1:0] angle0;
		logic signed [ANG_W-1:0] angle1;
	} tlt_push_t;

	typedef struct packed {
		logic                    done;
		logic signed [DEG_W-1:0] deg0;
		logic signed [DEG_W-1:0] deg1;
	} tlt_mean_t;

	// atan(2^-i) in q16 degrees
	function automatic logic [ACC_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [ACC_W-1:0] v;
		case (i)
			4'd0:    v = ACC_W'(2949120);
			4'd1:    v = ACC_W'(1740967);
			4'd2:    v = ACC_W'(919879);
			4'd3:    v = ACC_W'(466945);
			4'd4:    v = ACC_W'(234379);
			4'd5:    v = ACC_W'(117304);
			4'd6:    v = ACC_W'(58666);
			4'd7:    v = ACC_W'(29335);
			4'd8:    v = ACC_W'(14668);
			4'd9:    v = ACC_W'(7334);
			4'd10:   v = ACC_W'(3667);
			4'd11:   v = ACC_W'(1833);
			4'd12:   v = ACC_W'(917);
			4'd13:   v = ACC_W'(458);
			4'd14:   v = ACC_W'(229);
			4'd15:   v = ACC_W'(115);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/tlt_cordic_lane.sv
`timescale 1ns / 1ps
module tlt_cordic_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tlt_pkg::IN_W-1:0]     c_in,
	input  logic signed [tlt_pkg::IN_W-1:0]     s_in,
	output tlt_pkg::tlt_lane_res_t              res
);
	import tlt_pkg::*;

	localparam logic signed [ACC_W-1:0] TURN_HALF = ACC_W'(HALF_TURN);
	localparam logic signed [RND_W-1:0] RND_MAX   = RND_W'(ANG_LIMIT);
	localparam logic signed [ANG_W-1:0] ANG_MAX   = ANG_W'(ANG_LIMIT);

	logic signed [XY_W-1:0]  xv_q, yv_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [STEP_W-1:0]       cnt_q;
	logic                    busy_q, done_q, zero_q;

	logic signed [XY_W-1:0]  c_sc, s_sc, dx, dy;
	logic signed [ACC_W-1:0] step_ang, acc_rnd;
	logic signed [RND_W-1:0] rnd;
	logic signed [ANG_W-1:0] ang_sat;

	assign c_sc     = {{(XY_W-IN_W-SCALE_SH){c_in[IN_W-1]}}, c_in, {SCALE_SH{1'b0}}};
	assign s_sc     = {{(XY_W-IN_W-SCALE_SH){s_in[IN_W-1]}}, s_in, {SCALE_SH{1'b0}}};
	assign dx       = yv_q >>> cnt_q;
	assign dy       = xv_q >>> cnt_q;
	assign step_ang = signed'(atan_q16(cnt_q));

	// round to q8, then clamp to a half turn
	assign acc_rnd = acc_q + ACC_W'(128);
	assign rnd     = acc_rnd[ACC_W-1:FRAC_BITS];

	always_comb begin
		if (rnd > RND_MAX) begin
			ang_sat = ANG_MAX;
		end else if (rnd < -RND_MAX) begin
			ang_sat = -ANG_MAX;
		end else begin
			ang_sat = rnd[ANG_W-1:0];
		end
	end

	assign res.done  = done_q;
	assign res.angle = zero_q ? '0 : ang_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(STEPS-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (c_in == '0) && (s_in == '0);
			// fold into the right half plane
			if (c_in < 0) begin
				xv_q  <= -c_sc;
				yv_q  <= -s_sc;
				acc_q <= (s_in >= 0) ? TURN_HALF : -TURN_HALF;
			end else begin
				xv_q  <= c_sc;
				yv_q  <= s_sc;
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (yv_q > 0) begin
				xv_q  <= xv_q + dx;
				yv_q  <= yv_q - dy;
				acc_q <= acc_q + step_ang;
			end else begin
				xv_q  <= xv_q - dx;
				yv_q  <= yv_q + dy;
				acc_q <= acc_q - step_ang;
			end
		end
	end

endmodule

FILE: hdl/tlt_merge.sv
`timescale 1ns / 1ps
module tlt_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tlt_pkg::tlt_push_t    push,
	output tlt_pkg::tlt_mean_t    mean
);
	import tlt_pkg::*;

	logic signed [ANG_W-1:0] last0_q, last1_q;
	logic signed [ANG_W-1:0] ring0_q [AVG_DEPTH];
	logic signed [ANG_W-1:0] ring1_q [AVG_DEPTH];
	logic [POS_W-1:0]        pos_q;
	logic signed [SUM_W-1:0] sum0_q, sum1_q;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [Q_W-1:0]          q0_s2, q1_s2;
	logic                    neg0_s2, neg1_s2, neg0_s3, neg1_s3;
	logic [PROD_W-1:0]       prod0_s3, prod1_s3;
	logic signed [DEG_W-1:0] deg0_s4, deg1_s4;

	logic [POS_W:0]          pos_inc;
	logic [POS_W-1:0]        pos_nxt;
	logic signed [ANG_W-1:0] new0, new1;
	logic signed [SUM_W-1:0] mag0, mag1;
	logic [Q_W-1:0]          quot0, quot1;

	assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
	assign pos_nxt = (pos_inc < (POS_W+1)'(AVG_DEPTH)) ? pos_inc[POS_W-1:0] : '0;
	assign new0    = push.load_new ? push.angle0 : last0_q;
	assign new1    = push.load_new ? push.angle1 : last1_q;

	assign mag0  = sum0_q[SUM_W-1] ? -sum0_q : sum0_q;
	assign mag1  = sum1_q[SUM_W-1] ? -sum1_q : sum1_q;
	assign quot0 = prod0_s3[RECIP_SH +: Q_W];
	assign quot1 = prod1_s3[RECIP_SH +: Q_W];

	assign mean.done = v_s4;
	assign mean.deg0 = deg0_s4;
	assign mean.deg1 = deg1_s4;

	// ring sum kept as a running total: add the new entry, drop the one it replaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last0_q <= '0;
			last1_q <= '0;
			pos_q   <= '0;
			sum0_q  <= '0;
			sum1_q  <= '0;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				ring0_q[i] <= '0;
				ring1_q[i] <= '0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= push.push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (push.push) begin
				last0_q          <= new0;
				last1_q          <= new1;
				pos_q            <= pos_nxt;
				ring0_q[pos_nxt] <= new0;
				ring1_q[pos_nxt] <= new1;
				sum0_q <= sum0_q - SUM_W'(ring0_q[pos_nxt]) + SUM_W'(new0);
				sum1_q <= sum1_q - SUM_W'(ring1_q[pos_nxt]) + SUM_W'(new1);
			end
		end
	end

	// mean: magnitude, drop q8 fraction, reciprocal multiply, restore sign
	always_ff @(posedge clk) begin
		if (v_s1) begin
			neg0_s2 <= sum0_q[SUM_W-1];
			neg1_s2 <= sum1_q[SUM_W-1];
			q0_s2   <= mag0[MAG_W-1:FRAC_BITS];
			q1_s2   <= mag1[MAG_W-1:FRAC_BITS];
		end
		if (v_s2) begin
			neg0_s3  <= neg0_s2;
			neg1_s3  <= neg1_s2;
			prod0_s3 <= PROD_W'(q0_s2) * PROD_W'(RECIP);
			prod1_s3 <= PROD_W'(q1_s2) * PROD_W'(RECIP);
		end
		if (v_s3) begin
			deg0_s4 <= neg0_s3 ? -DEG_W'(quot0) : DEG_W'(quot0);
			deg1_s4 <= neg1_s3 ? -DEG_W'(quot1) : DEG_W'(quot1);
		end
	end

endmodule

FILE: hdl/tilt_angle_moving_average_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata x, y, z readings; tuser frame_valid
// m_*       out  m_tvalid/m_tready  tdata first, second mean angle in degrees
//
// one item at a time; a valid frame runs the 16 cordic steps in both lanes side
// by side, then the ring update and mean, before the next accept
// an invalid frame skips the lanes and goes straight to the ring update and mean
// reset clears the ring, the last angles and the write slot at once
// the output register holds a result while m_tready is low; the block stalls
// before loading the next result until it has been taken
module tilt_angle_moving_average_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// x_reading [15:0], y_reading [31:16], z_reading [47:32]
	input  logic [tlt_pkg::IN_DATA_W-1:0]  s_tdata,
	// frame_valid [0]
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// first_angle_deg [8:0], second_angle_deg [17:9], zero [23:18]
	output logic [tlt_pkg::OUT_W-1:0]      m_tdata
);
	import tlt_pkg::*;

	tlt_state_t    state_q, state_d;
	tlt_lane_res_t res0, res1;
	tlt_push_t     push;
	tlt_mean_t     mean;
	logic          lane_start, load_out;
	logic          m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic signed [IN_W-1:0] x_rd, y_rd, z_rd;

	assign x_rd = s_tdata[IN_W-1:0];
	assign y_rd = s_tdata[2*IN_W-1:IN_W];
	assign z_rd = s_tdata[3*IN_W-1:2*IN_W];

	tlt_cordic_lane u_lane0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.c_in   (x_rd),
		.s_in   (z_rd),
		.res    (res0)
	);

	tlt_cordic_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.c_in   (y_rd),
		.s_in   (z_rd),
		.res    (res1)
	);

	tlt_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.mean   (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		lane_start      = 1'b0;
		load_out        = 1'b0;
		push.push       = 1'b0;
		push.load_new   = 1'b0;
		push.angle0     = res0.angle;
		push.angle1     = res1.angle;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser[0]) begin
						lane_start = 1'b1;
						state_d    = ST_CORDIC;
					end else begin
						// no new reading: repeat the last angles
						push.push = 1'b1;
						state_d   = ST_MERGE;
					end
				end
			end
			ST_CORDIC: begin
				if (res0.done) begin
					push.push     = 1'b1;
					push.load_new = 1'b1;
					state_d       = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (mean.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{(OUT_W-2*DEG_W){1'b0}}, mean.deg1, mean.deg0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hdl/tlt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tlt_pkg::OUT_W-1:0] m_tdata
);
	import tlt_pkg::*;

	`TLT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`TLT_ASSERT_NEXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata))
	// a new item is not taken while the last one is still at work
	`TLT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	// a result only appears at the end of an item's work
	`TLT_ASSERT(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind tilt_angle_moving_average_top tlt_checker u_tlt_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_TAIL    = 150;
	localparam int PARK_CYCLES  = 400;
	localparam int SETTLE       = 60;
	localparam int MEAN_DIV     = tlt_pkg::AVG_DEPTH * 256;
	localparam longint SAT_Q8   = 46080;
	localparam longint ARCTAN_Q16 [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	typedef struct {
		logic [15:0] x_reading;
		logic [15:0] y_reading;
		logic [15:0] z_reading;
		logic        frame_valid;
		bit          await_drain;
	} reading_t;

	typedef struct {
		logic signed [tlt_pkg::DEG_W-1:0] first_deg;
		logic signed [tlt_pkg::DEG_W-1:0] second_deg;
	} mean_pair_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [tlt_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [0:0]                    s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [tlt_pkg::OUT_W-1:0]     m_tdata;

	reading_t   pending_readings[$];
	mean_pair_t expected_means[$];

	// predictor state
	longint held_angle_x;
	longint held_angle_y;
	longint angle_hist_x [tlt_pkg::AVG_DEPTH];
	longint angle_hist_y [tlt_pkg::AVG_DEPTH];
	int     hist_slot;

	bit took_item = 1'b0;
	bit sink_parked = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;
	int items_taken = 0;
	int mismatches = 0;

	tilt_angle_moving_average_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic log_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// vectoring cordic, angle of (c, s) in q8 degrees
	function automatic longint tilt_q8(input longint c, input longint s);
		longint xv, yv, acc, dx, dy, r;
		int k;
		acc = 0;
		if (c == 0 && s == 0)
			return 0;
		xv = c * 16384;
		yv = s * 16384;
		// fold into the right half plane
		if (xv < 0) begin
			acc = (yv >= 0) ? 180 * 65536 : -180 * 65536;
			xv = -xv;
			yv = -yv;
		end
		for (k = 0; k < 16; k++) begin
			dx = yv >>> k;
			dy = xv >>> k;
			if (yv > 0) begin
				xv = xv + dx;
				yv = yv - dy;
				acc = acc + ARCTAN_Q16[k];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				acc = acc - ARCTAN_Q16[k];
			end
		end
		r = (acc + 128) >>> 8;
		if (r > SAT_Q8)
			r = SAT_Q8;
		if (r < -SAT_Q8)
			r = -SAT_Q8;
		return r;
	endfunction

	function automatic mean_pair_t predict_means(input logic [tlt_pkg::IN_DATA_W-1:0] d,
			input logic fv);
		mean_pair_t res;
		longint sum_x, sum_y, zr;
		int k;
		sum_x = 0;
		sum_y = 0;
		if (fv) begin
			zr = longint'($signed(d[47:32]));
			held_angle_x = tilt_q8(longint'($signed(d[15:0])), zr);
			held_angle_y = tilt_q8(longint'($signed(d[31:16])), zr);
		end
		hist_slot = (hist_slot + 1 < tlt_pkg::AVG_DEPTH) ? hist_slot + 1 : 0;
		angle_hist_x[hist_slot] = held_angle_x;
		angle_hist_y[hist_slot] = held_angle_y;
		for (k = 0; k < tlt_pkg::AVG_DEPTH; k++) begin
			sum_x += angle_hist_x[k];
			sum_y += angle_hist_y[k];
		end
		// signed division truncates toward zero
		res.first_deg = tlt_pkg::DEG_W'(sum_x / MEAN_DIV);
		res.second_deg = tlt_pkg::DEG_W'(sum_y / MEAN_DIV);
		return res;
	endfunction

	task automatic add_reading(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic fv, input bit drain);
		reading_t r;
		r.x_reading = x;
		r.y_reading = y;
		r.z_reading = z;
		r.frame_valid = fv;
		r.await_drain = drain;
		pending_readings.push_back(r);
	endtask

	function automatic logic [15:0] edge_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic logic [15:0] tiny_value();
		int v;
		v = $urandom_range(0, 6);
		v = v - 3;
		return v[15:0];
	endfunction

	task automatic add_random_reading(input bit drain);
		logic [15:0] x, y, z;
		logic fv;
		fv = 1'b1;
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		case ($urandom_range(0, 9))
			0: fv = 1'b0;
			1: begin
				x = tiny_value();
				y = tiny_value();
				z = tiny_value();
			end
			2: begin
				x = edge_value();
				y = edge_value();
				z = edge_value();
			end
			3: begin
				// vectors on or near an axis
				if ($urandom_range(0, 1))
					z = tiny_value();
				else begin
					x = tiny_value();
					y = tiny_value();
				end
			end
			default: ;
		endcase
		add_reading(x, y, z, fv, drain);
	endtask

	// driver
	always @(negedge clk) begin
		reading_t nxt;
		bit offer;
		logic [tlt_pkg::IN_DATA_W-1:0] word;
		logic [0:0] flag;
		offer = 1'b0;
		word = {16'($urandom), 16'($urandom), 16'($urandom)};
		flag = 1'($urandom);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || took_item) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
			end else if (pending_readings.size() > 0) begin
				if (pending_readings[0].await_drain && expected_means.size() > 0) begin
					// hold off until every result is back
				end else if (pending_readings.size() >= CALM_TAIL
						&& $urandom_range(0, 5) == 0) begin
					src_gap <= $urandom_range(0, 10);
				end else begin
					nxt = pending_readings.pop_front();
					offer = 1'b1;
					word = {nxt.z_reading, nxt.y_reading, nxt.x_reading};
					flag = nxt.frame_valid;
				end
			end
			s_tvalid <= offer;
			s_tdata <= word;
			s_tuser <= flag;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n || sink_parked) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_tready <= 1'b0;
		end else if (pending_readings.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
			sink_gap <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		mean_pair_t want;
		took_item <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expected_means.push_back(predict_means(s_tdata, s_tuser[0]));
			items_taken <= items_taken + 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_means.size() == 0) begin
				log_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
			end else begin
				want = expected_means.pop_front();
				if ($signed(m_tdata[8:0]) != want.first_deg)
					log_mismatch($sformatf("first_angle_deg got %0d want %0d",
						$signed(m_tdata[8:0]), want.first_deg));
				if ($signed(m_tdata[17:9]) != want.second_deg)
					log_mismatch($sformatf("second_angle_deg got %0d want %0d",
						$signed(m_tdata[17:9]), want.second_deg));
				if (m_tdata[23:18] != '0)
					log_mismatch($sformatf("pad bits got %h", m_tdata[23:18]));
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (items_taken >= 300);
		@(posedge clk);
		sink_parked = 1'b1;
		repeat (PARK_CYCLES) @(posedge clk);
		sink_parked = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int k;
		held_angle_x = 0;
		held_angle_y = 0;
		hist_slot = 0;
		for (k = 0; k < tlt_pkg::AVG_DEPTH; k++) begin
			angle_hist_x[k] = 0;
			angle_hist_y[k] = 0;
		end

		// directed part
		add_reading(16'h04D2, 16'hF00F, 16'h7FFF, 1'b0, 1'b0);
		add_reading(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
		add_reading(16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b0);
		add_reading(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
		add_reading(16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
		add_reading(16'h0000, 16'h0000, 16'h7FFF, 1'b1, 1'b0);
		add_reading(16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b0);
		add_reading(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, 1'b0);
		add_reading(16'h8000, 16'h8001, 16'h0001, 1'b1, 1'b0);
		add_reading(16'h8000, 16'h8000, 16'hFFFF, 1'b1, 1'b0);
		// invalid frames keep the last angles whatever the data
		add_reading(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		add_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		add_reading(16'h0001, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
		add_reading(16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
		add_reading(16'hFFFB, 16'h0003, 16'hFFF9, 1'b1, 1'b0);
		add_reading(16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0);
		add_reading(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);
		add_reading(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
		add_reading(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
		add_reading(16'h0064, 16'hFF38, 16'h012C, 1'b1, 1'b1);
		add_reading(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);

		for (k = 0; k < RANDOM_ITEMS; k++)
			add_random_reading(k == 500 || k == 900);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_readings.size() != 0 || s_tvalid || expected_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
